### design/assert_macros.svh
// Assertion helpers for the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BGELU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define BGELU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/bgelu_pkg.sv
package bgelu_pkg;

    // Default data format: signed Q5.10
    localparam int DATA_WIDTH_DEFAULT = 16;
    localparam int FRAC_BITS_DEFAULT  = 10;

    // Phi is held as unsigned Q0.16, 0..65536, so 17 bits
    localparam int PHI_W = 17;
    localparam logic [PHI_W-1:0] PHI_ONE  = 17'h10000;
    localparam logic [PHI_W-1:0] PHI_HALF = 17'h08000;

    // Table: Phi(k/8) for k = 0..32
    localparam int TABLE_STEP_LOG2 = 3;
    localparam int SEG_BITS        = 5;
    localparam int IDX_W           = 6;
    localparam logic [IDX_W-1:0] PHI_SEGS = 6'd32;

    // Rounding offset for the final Q0.16 product
    localparam logic [PHI_W-1:0] ROUND_HALF = 17'h08000;

    // round(65536 * Phi(k/8))
    function automatic logic [PHI_W-1:0] phi_lut(input logic [IDX_W-1:0] idx);
        logic [PHI_W-1:0] val;
        case (idx)
            6'd0:  val = 17'd32768;
            6'd1:  val = 17'd36028;
            6'd2:  val = 17'd39237;
            6'd3:  val = 17'd42347;
            6'd4:  val = 17'd45316;
            6'd5:  val = 17'd48104;
            6'd6:  val = 17'd50684;
            6'd7:  val = 17'd53033;
            6'd8:  val = 17'd55138;
            6'd9:  val = 17'd56997;
            6'd10: val = 17'd58612;
            6'd11: val = 17'd59994;
            6'd12: val = 17'd61158;
            6'd13: val = 17'd62123;
            6'd14: val = 17'd62911;
            6'd15: val = 17'd63544;
            6'd16: val = 17'd64045;
            6'd17: val = 17'd64435;
            6'd18: val = 17'd64735;
            6'd19: val = 17'd64961;
            6'd20: val = 17'd65129;
            6'd21: val = 17'd65252;
            6'd22: val = 17'd65341;
            6'd23: val = 17'd65404;
            6'd24: val = 17'd65448;
            6'd25: val = 17'd65478;
            6'd26: val = 17'd65498;
            6'd27: val = 17'd65512;
            6'd28: val = 17'd65521;
            6'd29: val = 17'd65527;
            6'd30: val = 17'd65530;
            6'd31: val = 17'd65533;
            6'd32: val = 17'd65534;
            default: val = PHI_ONE;
        endcase
        return val;
    endfunction

endpackage

### design/bgelu_bias_sat.sv
// Stage 1: bias add with saturation, split into sign and magnitude
module bgelu_bias_sat #(
    parameter int DATA_WIDTH = bgelu_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] activation,
    input  logic signed [DATA_WIDTH-1:0] bias_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_neg,
    output logic        [DATA_WIDTH-1:0] out_mag
);

    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  valid_reg;
    logic                  neg_reg;
    logic [DATA_WIDTH-1:0] mag_reg;
    logic [DATA_WIDTH:0]   sum;
    logic [DATA_WIDTH-1:0] sat_v;
    logic                  neg_next;
    logic [DATA_WIDTH-1:0] mag_next;

    assign in_ready = !valid_reg || out_ready;

    // Extended sum, clamp on overflow
    always_comb begin
        sum = {activation[DATA_WIDTH-1], activation} + {bias_value[DATA_WIDTH-1], bias_value};
        if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) begin
            sat_v = sum[DATA_WIDTH] ? SAT_MIN : SAT_MAX;
        end else begin
            sat_v = sum[DATA_WIDTH-1:0];
        end
        neg_next = sat_v[DATA_WIDTH-1];
        // most negative value maps to 2^(DW-1) as unsigned
        mag_next = neg_next ? (~sat_v + 1'b1) : sat_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_mag   = mag_reg;

endmodule

### design/bgelu_phi.sv
// Stages 2 to 4: Phi(v) from the table with linear interpolation
module bgelu_phi #(
    parameter int DATA_WIDTH = bgelu_pkg::DATA_WIDTH_DEFAULT,
    parameter int FRAC_BITS  = bgelu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_neg,
    input  logic [DATA_WIDTH-1:0]          in_mag,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_neg,
    output logic [DATA_WIDTH-1:0]          out_mag,
    output logic [bgelu_pkg::PHI_W-1:0]    out_phi
);

    localparam int PW    = bgelu_pkg::PHI_W;
    localparam int IW    = bgelu_pkg::IDX_W;
    localparam int SHIFT = FRAC_BITS - bgelu_pkg::TABLE_STEP_LOG2;
    // magnitude widened so that the fraction select always exists
    localparam int EXT_W = (DATA_WIDTH > SHIFT + bgelu_pkg::SEG_BITS) ?
                           DATA_WIDTH : SHIFT + bgelu_pkg::SEG_BITS;
    localparam int PROD_W = PW + SHIFT;

    // stage 2: table look-up
    logic                  v2_reg;
    logic                  neg2_reg;
    logic                  big2_reg;
    logic [DATA_WIDTH-1:0] mag2_reg;
    logic [PW-1:0]         lo2_reg;
    logic [PW-1:0]         d2_reg;
    logic [SHIFT-1:0]      f2_reg;
    // stage 3: slope times fraction
    logic                  v3_reg;
    logic                  neg3_reg;
    logic                  big3_reg;
    logic [DATA_WIDTH-1:0] mag3_reg;
    logic [PW-1:0]         lo3_reg;
    logic [PROD_W-1:0]     prod3_reg;
    // stage 4: interpolated, mirrored Phi
    logic                  v4_reg;
    logic                  neg4_reg;
    logic [DATA_WIDTH-1:0] mag4_reg;
    logic [PW-1:0]         phi4_reg;

    logic rdy2, rdy3, rdy4;

    logic [EXT_W-1:0]          mag_ext;
    logic [EXT_W-1:0]          seg_full;
    logic [IW-1:0]             idx_lo;
    logic [IW-1:0]             idx_hi;
    logic [PW-1:0]             lo_next;
    logic [PW-1:0]             d_next;
    logic                      big_next;
    logic [PROD_W-1:0]         prod_next;
    logic [PW:0]               interp_sum;
    logic [PW-1:0]             phi_abs;
    logic [PW-1:0]             phi_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    // Segment and neighbouring table entries
    always_comb begin
        mag_ext  = EXT_W'(in_mag);
        seg_full = mag_ext >> SHIFT;
        big_next = (seg_full >= EXT_W'(bgelu_pkg::PHI_SEGS));
        idx_lo   = {1'b0, seg_full[bgelu_pkg::SEG_BITS-1:0]};
        idx_hi   = idx_lo + 1'b1;
        lo_next  = bgelu_pkg::phi_lut(idx_lo);
        d_next   = bgelu_pkg::phi_lut(idx_hi) - lo_next;
    end

    // Slope product
    assign prod_next = {{SHIFT{1'b0}}, d2_reg} * {{PW{1'b0}}, f2_reg};

    // Interpolate, clamp large magnitudes, mirror for negative inputs
    always_comb begin
        interp_sum = {1'b0, lo3_reg} + {1'b0, prod3_reg[PROD_W-1:SHIFT]};
        phi_abs    = big3_reg ? bgelu_pkg::PHI_ONE : interp_sum[PW-1:0];
        phi_next   = neg3_reg ? (bgelu_pkg::PHI_ONE - phi_abs) : phi_abs;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy2) v2_reg <= in_valid;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (rdy2 && in_valid) begin
            neg2_reg <= in_neg;
            big2_reg <= big_next;
            mag2_reg <= in_mag;
            lo2_reg  <= lo_next;
            d2_reg   <= d_next;
            f2_reg   <= mag_ext[SHIFT-1:0];
        end
        if (rdy3 && v2_reg) begin
            neg3_reg  <= neg2_reg;
            big3_reg  <= big2_reg;
            mag3_reg  <= mag2_reg;
            lo3_reg   <= lo2_reg;
            prod3_reg <= prod_next;
        end
        if (rdy4 && v3_reg) begin
            neg4_reg <= neg3_reg;
            mag4_reg <= mag3_reg;
            phi4_reg <= phi_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_neg   = neg4_reg;
    assign out_mag   = mag4_reg;
    assign out_phi   = phi4_reg;

endmodule

### design/bgelu_product.sv
// Stages 5 and 6: v * Phi(v), rounded, with the sign restored
module bgelu_product #(
    parameter int DATA_WIDTH = bgelu_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_neg,
    input  logic [DATA_WIDTH-1:0]        in_mag,
    input  logic [bgelu_pkg::PHI_W-1:0]  in_phi,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] out_data
);

    localparam int PW = bgelu_pkg::PHI_W;
    localparam int MW = DATA_WIDTH + PW;

    logic                  v5_reg;
    logic                  neg5_reg;
    logic [DATA_WIDTH-1:0] mag5_reg;
    logic                  v6_reg;
    logic [DATA_WIDTH-1:0] out6_reg;
    logic                  rdy5, rdy6;

    logic [MW-1:0]         prod;
    logic [MW-1:0]         rounded;
    logic [DATA_WIDTH-1:0] mag_next;
    logic [DATA_WIDTH-1:0] out_next;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign in_ready = rdy5;

    // Q0.16 product, rounded half up; never exceeds the input magnitude
    always_comb begin
        prod     = {{PW{1'b0}}, in_mag} * {{DATA_WIDTH{1'b0}}, in_phi};
        rounded  = prod + {{DATA_WIDTH{1'b0}}, bgelu_pkg::ROUND_HALF};
        mag_next = rounded[DATA_WIDTH+15:16];
    end

    // Sign restore; magnitude bound keeps this inside the range
    assign out_next = neg5_reg ? (~mag5_reg + 1'b1) : mag5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy5) v5_reg <= in_valid;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && in_valid) begin
            neg5_reg <= in_neg;
            mag5_reg <= mag_next;
        end
        if (rdy6 && v5_reg) begin
            out6_reg <= out_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = out6_reg;

endmodule

### design/bias_add_gelu_erf.sv
// Fused bias add and GELU (erf form), signed fixed point, Q5.10 by default.
// Input channel s_*: one item is an activation and its channel bias; it is
// taken when s_valid and s_ready are both high on a rising edge of aclk.
// Result channel m_*: one item per input item, m_gelu_out = GELU(x + b),
// in input order, handed over when m_valid and m_ready are both high.
// Path: each item passes the six registered stages in order (bias add, table
// look-up, slope multiply, interpolation, magnitude multiply, sign).
// Throughput: one item per cycle while m_ready stays high, set by the
// six-stage register pipeline; every stage has its own valid bit and takes a
// new item whenever it is empty or its successor moves on.
// When the receiver holds m_ready low, the output stage keeps its item and
// the stages behind it fill up; s_ready drops only once all six are full,
// and nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline; there is no
// other state, so the block is ready as soon as reset is released.
`include "assert_macros.svh"

module bias_add_gelu_erf #(
    parameter int DATA_WIDTH = bgelu_pkg::DATA_WIDTH_DEFAULT,
    parameter int FRAC_BITS  = bgelu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_activation,
    input  logic signed [DATA_WIDTH-1:0] s_bias_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_gelu_out
);

    logic                        sat_valid, sat_ready, sat_neg;
    logic [DATA_WIDTH-1:0]       sat_mag;
    logic                        phi_valid, phi_ready, phi_neg;
    logic [DATA_WIDTH-1:0]       phi_mag;
    logic [bgelu_pkg::PHI_W-1:0] phi_p;

    bgelu_bias_sat #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_bias_sat (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .activation (s_activation),
        .bias_value (s_bias_value),
        .out_valid  (sat_valid),
        .out_ready  (sat_ready),
        .out_neg    (sat_neg),
        .out_mag    (sat_mag)
    );

    bgelu_phi #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_phi (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sat_valid),
        .in_ready  (sat_ready),
        .in_neg    (sat_neg),
        .in_mag    (sat_mag),
        .out_valid (phi_valid),
        .out_ready (phi_ready),
        .out_neg   (phi_neg),
        .out_mag   (phi_mag),
        .out_phi   (phi_p)
    );

    bgelu_product #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_product (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (phi_valid),
        .in_ready  (phi_ready),
        .in_neg    (phi_neg),
        .in_mag    (phi_mag),
        .in_phi    (phi_p),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_gelu_out)
    );

    // Phi of a non-negative value lies in the upper half, of a negative one in the lower
    `BGELU_ASSERT_IMP(a_phi_pos_half, aclk, aresetn, phi_valid && !phi_neg, phi_p >= bgelu_pkg::PHI_HALF && phi_p <= bgelu_pkg::PHI_ONE)
    `BGELU_ASSERT_IMP(a_phi_neg_half, aclk, aresetn, phi_valid && phi_neg, phi_p <= bgelu_pkg::PHI_HALF)
    // A non-negative saturated sum never reaches the sign bit
    `BGELU_ASSERT_IMP(a_sat_pos_range, aclk, aresetn, sat_valid && !sat_neg, !sat_mag[DATA_WIDTH-1])
    // A held phi item is still there in the next cycle
    `BGELU_ASSERT_NXT(a_phi_hold, aclk, aresetn, phi_valid && !phi_ready, phi_valid && $stable(phi_p))

endmodule

### verif/bgelu_checker.sv
`timescale 1ns / 100ps

module bgelu_checker #(
    parameter int DW = bgelu_pkg::DATA_WIDTH_DEFAULT,
    parameter int FB = bgelu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic signed [DW-1:0] s_activation,
    input  logic signed [DW-1:0] s_bias_value,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [DW-1:0] m_gelu_out,
    output int                   mismatches,
    output int                   pending,
    output int                   items_in,
    output int                   results_out,
    output int                   sat_sums,
    output int                   big_mags
);

    // Phi(k/8) in Q0.16, k = 0..32
    int phi_tab [33] = '{
        32768, 36028, 39237, 42347, 45316, 48104, 50684, 53033,
        55138, 56997, 58612, 59994, 61158, 62123, 62911, 63544,
        64045, 64435, 64735, 64961, 65129, 65252, 65341, 65404,
        65448, 65478, 65498, 65512, 65521, 65527, 65530, 65533,
        65534
    };

    logic signed [DW-1:0] gelu_q [$];

    // Saturating sum of activation and bias
    function automatic longint sat_sum(input logic signed [DW-1:0] x,
                                       input logic signed [DW-1:0] b);
        longint lim_hi;
        longint v;
        lim_hi = (longint'(1) <<< (DW - 1)) - 1;
        v = longint'(x) + longint'(b);
        if (v > lim_hi) begin
            v = lim_hi;
        end else if (v < -lim_hi - 1) begin
            v = -lim_hi - 1;
        end
        return v;
    endfunction

    // GELU of the saturated sum: table Phi with linear interpolation
    function automatic logic signed [DW-1:0] gelu_predict(input logic signed [DW-1:0] x,
                                                          input logic signed [DW-1:0] b);
        longint lim_hi;
        longint v;
        longint a;
        longint seg;
        longint frac;
        longint p;
        longint mag;
        longint r;
        int     sh;
        bit     neg;
        lim_hi = (longint'(1) <<< (DW - 1)) - 1;
        sh     = FB - 3;
        v      = sat_sum(x, b);
        neg    = (v < 0);
        a      = neg ? -v : v;
        seg    = a >>> sh;
        frac   = a & ((longint'(1) <<< sh) - 1);
        if (seg >= 32) begin
            p = 65536;
        end else begin
            p = longint'(phi_tab[int'(seg)]) +
                (((longint'(phi_tab[int'(seg) + 1]) - longint'(phi_tab[int'(seg)])) * frac)
                 >>> sh);
        end
        // erf is odd, so Phi(-a) = 1 - Phi(a)
        if (neg) begin
            p = 65536 - p;
        end
        mag = (a * p + 32768) >>> 16;
        r   = neg ? -mag : mag;
        if (r > lim_hi) begin
            r = lim_hi;
        end else if (r < -lim_hi - 1) begin
            r = -lim_hi - 1;
        end
        return r[DW-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches = mismatches + 1;
    endtask

    // Compare results first, then record the item taken on this edge
    always @(posedge aclk) begin
        logic signed [DW-1:0] want;
        longint               sum;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_out = results_out + 1;
                if (gelu_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", m_gelu_out));
                end else begin
                    want = gelu_q.pop_front();
                    if (m_gelu_out !== want) begin
                        report_mismatch($sformatf("result %0d: gelu_out %0d, wanted %0d",
                                                  results_out, m_gelu_out, want));
                    end
                end
            end
            if (s_valid && s_ready) begin
                items_in = items_in + 1;
                gelu_q.push_back(gelu_predict(s_activation, s_bias_value));
                sum = longint'(s_activation) + longint'(s_bias_value);
                if (sum != sat_sum(s_activation, s_bias_value)) begin
                    sat_sums = sat_sums + 1;
                end
                if (sat_sum(s_activation, s_bias_value) >= (longint'(4) <<< FB) ||
                    sat_sum(s_activation, s_bias_value) <= -(longint'(4) <<< FB)) begin
                    big_mags = big_mags + 1;
                end
            end
            pending = gelu_q.size();
        end
    end

endmodule

### verif/tb_bias_add_gelu_erf.sv
`timescale 1ns / 100ps

module tb_bias_add_gelu_erf;

    localparam int DW        = bgelu_pkg::DATA_WIDTH_DEFAULT;
    localparam int FB        = bgelu_pkg::FRAC_BITS_DEFAULT;
    localparam int N_RANDOM  = 1800;
    localparam int FOUR      = 4 << FB;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [DW-1:0] s_activation = '0;
    logic signed [DW-1:0] s_bias_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [DW-1:0] m_gelu_out;

    int mismatches;
    int pending;
    int items_in;
    int results_out;
    int sat_sums;
    int big_mags;

    // receiver stall state
    int   rx_mode;
    int   rx_left;
    int   rx_hold;
    logic rx_level;

    always #5 aclk = ~aclk;

    bias_add_gelu_erf dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_activation (s_activation),
        .s_bias_value (s_bias_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gelu_out   (m_gelu_out)
    );

    bgelu_checker #(.DW(DW), .FB(FB)) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_activation (s_activation),
        .s_bias_value (s_bias_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gelu_out   (m_gelu_out),
        .mismatches   (mismatches),
        .pending      (pending),
        .items_in     (items_in),
        .results_out  (results_out),
        .sat_sums     (sat_sums),
        .big_mags     (big_mags)
    );

    // Present one item at the falling edge and hold it until taken
    task automatic send_item(input int x, input int b);
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_activation <= x[DW-1:0];
        s_bias_value <= b[DW-1:0];
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Drop valid for a number of cycles
    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // Hold off until every result still owed has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);
    endtask

    // Random item: half near the interpolated range, some full range, some at edges, some overflowing
    task automatic send_random();
        int kind;
        int x;
        int b;
        int t;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            t = $urandom_range(0, 2 * FOUR + 1200);
            x = t - FOUR - 600;
            t = $urandom_range(0, 400);
            b = t - 200;
        end else if (kind < 8) begin
            x = $signed(DW'($urandom()));
            b = $signed(DW'($urandom()));
        end else if (kind < 9) begin
            // near a table segment edge or the clamp point
            t = $urandom_range(0, 33);
            x = (t << (FB - 3)) + $urandom_range(0, 4) - 2;
            if ($urandom_range(0, 1)) begin
                x = -x;
            end
            b = 0;
        end else begin
            // sums that overflow one way or the other
            t = $urandom_range(16384, 32767);
            x = t;
            t = $urandom_range(16384, 32767);
            b = t;
            if ($urandom_range(0, 1)) begin
                x = -x - 1;
                b = -b - 1;
            end
        end
        send_item(x, b);
    endtask

    // Receiver: ready pattern changes mode every so often
    initial begin
        rx_mode  = 0;
        rx_left  = 0;
        rx_hold  = 0;
        rx_level = 1'b1;
        forever begin
            @(negedge aclk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left = rx_left - 1;
            case (rx_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 4) != 0);
                end
                default: begin
                    // long runs high and low
                    if (rx_hold == 0) begin
                        rx_hold  = $urandom_range(1, 20);
                        rx_level = ~rx_level;
                    end
                    rx_hold  = rx_hold - 1;
                    m_ready <= rx_level;
                end
            endcase
        end
    end

    // Stimulus and verdict
    initial begin
        int sent;
        int burst;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero, extremes, overflow, clamp point, segment edges
        send_item(0, 0);
        send_item(32767, 0);
        send_item(-32768, 0);
        send_item(32767, 32767);
        send_item(-32768, -32768);
        send_item(32767, -32768);
        send_item(32767, 1);
        send_item(-32768, -1);
        send_item(FOUR, 0);
        send_item(FOUR - 1, 0);
        send_item(-FOUR, 0);
        send_item(-FOUR + 1, 0);
        send_item(4000, FOUR - 4000);
        send_item(1, 0);
        send_item(-1, 0);
        send_item(127, 0);
        send_item(128, 0);
        send_item(-128, 0);
        send_item(1 << FB, 0);
        send_item(-(1 << FB), 0);
        send_item(20000, 20000);
        send_item(-20000, -20000);
        send_item(21845, -10923);
        send_item(-21846, 10922);
        drain_results();

        // random bursts with gaps
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_random();
                sent = sent + 1;
            end
            if (sent >= N_RANDOM / 2 && sent - burst < N_RANDOM / 2) begin
                drain_results();
            end else if ($urandom_range(0, 3) != 0) begin
                sender_gap($urandom_range(1, 8));
            end
        end

        // wait out the pipeline
        drain_results();
        repeat (20) @(posedge aclk);

        $display("Covered %0d items and %0d results across all ready patterns,",
                 items_in, results_out);
        $display("including %0d saturated sums and %0d clamped magnitudes.",
                 sat_sums, big_mags);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Timed out with %0d results outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### bias_add_gelu_erf.f
+incdir+design
design/bgelu_pkg.sv
design/bgelu_bias_sat.sv
design/bgelu_phi.sv
design/bgelu_product.sv
design/bias_add_gelu_erf.sv
verif/bgelu_checker.sv
verif/tb_bias_add_gelu_erf.sv
